// ===== rtl/core/gfus2d_pkg.sv =====
// ----------------------------------------------------------------------------
// gfus2d_pkg
// Beat types and fixed widths shared by the 2D Gaussian fusion datapath.
// ----------------------------------------------------------------------------
package gfus2d_pkg;

   localparam int MW     = 32;          // mean, Q16.16 signed
   localparam int DGW    = 39;          // covariance diagonal, Q7.32 unsigned
   localparam int OFW    = 40;          // covariance off-diagonal, Q8.32 signed
   localparam int EW     = 40;          // covariance element as signed value
   localparam int SW     = 41;          // element of A+B
   localparam int DETW   = 82;          // det(A+B)
   localparam int QW     = 82;          // adj(A+B) * A
   localparam int TW     = 74;          // adj(A+B) * mean
   localparam int NUMW   = 122;         // divider numerators
   localparam int CHUNK  = 21;          // multiplier operand slice
   localparam int QBITS  = 41;          // quotient magnitude bits before clamp
   localparam int QOW    = QBITS + 2;   // signed rounded quotient
   localparam int MULLAT = 2;
   localparam int DIVLAT = QBITS + 2;

   typedef struct packed {
      logic signed [MW-1:0]  mean_a_x;
      logic signed [MW-1:0]  mean_a_y;
      logic        [DGW-1:0] cov_a_xx;
      logic signed [OFW-1:0] cov_a_xy;
      logic        [DGW-1:0] cov_a_yy;
      logic signed [MW-1:0]  mean_b_x;
      logic signed [MW-1:0]  mean_b_y;
      logic        [DGW-1:0] cov_b_xx;
      logic signed [OFW-1:0] cov_b_xy;
      logic        [DGW-1:0] cov_b_yy;
   } gfus2d_req_type;

   typedef struct packed {
      logic signed [MW-1:0]  fused_x;
      logic signed [MW-1:0]  fused_y;
      logic        [DGW-1:0] fused_cov_xx;
      logic signed [OFW-1:0] fused_cov_xy;
      logic        [DGW-1:0] fused_cov_yy;
      logic                  singular;
   } gfus2d_rsp_type;

endpackage

// ===== rtl/core/gfus2d_mul.sv =====
// ----------------------------------------------------------------------------
// gfus2d_mul
// Two-stage signed multiplier: b is cut into slices, partial products are
// registered, then summed into a registered product.
// ----------------------------------------------------------------------------
module gfus2d_mul #(
   parameter int WA = 40,
   parameter int WB = 41,
   parameter int CW = 21
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [WA-1:0]  a,
   input  logic signed [WB-1:0]  b,
   output logic signed [WA+WB-1:0] p
);

   localparam int NC = (WB + CW - 1) / CW;
   localparam int BW = NC * CW;
   localparam int PW = WA + WB;

   logic signed [BW-1:0] b_ext;
   logic signed [PW-1:0] part_in [NC];
   logic signed [PW-1:0] part_ff [NC];
   logic signed [PW-1:0] p_in;
   logic signed [PW-1:0] p_ff;

   assign b_ext = BW'(b);

   for (genvar k = 0; k < NC; k++) begin : g_part
      if (k == NC - 1) begin : g_top
         // top slice carries the sign
         assign part_in[k] = PW'(a) * PW'($signed(b_ext[k*CW +: CW]));
      end else begin : g_low
         assign part_in[k] = PW'(a) * PW'($signed({1'b0, b_ext[k*CW +: CW]}));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         part_ff <= part_in;
      end
   end

   always_comb begin
      p_in = '0;
      for (int k = 0; k < NC; k++) begin
         p_in = p_in + (part_ff[k] <<< (k * CW));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/core/gfus2d_dly.sv =====
// ----------------------------------------------------------------------------
// gfus2d_dly
// Stallable delay line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module gfus2d_dly #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] tap_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[N-1];

endmodule

// ===== rtl/core/gfus2d_div.sv =====
// ----------------------------------------------------------------------------
// gfus2d_div
// Pipelined restoring divider, one quotient bit per stage, round to nearest
// with ties away from zero. Quotients of 2^K or more come out as +/-2^K.
// ----------------------------------------------------------------------------
module gfus2d_div #(
   parameter int NW = 122,
   parameter int DW = 82,
   parameter int K  = 41
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic signed [K+1:0]  quo
);

   logic [NW-1:0] un;
   logic [DW-1:0] ud;

   logic [DW-1:0] rem_ff [K+1];
   logic [DW-1:0] rem_in [K+1];
   logic [K-1:0]  low_ff [K+1];
   logic [K-1:0]  low_in [K+1];
   logic [K-1:0]  q_ff   [K+1];
   logic [K-1:0]  q_in   [K+1];
   logic [DW-1:0] ud_ff  [K+1];
   logic [K:0]    neg_ff;
   logic [K:0]    ovf_ff;
   logic [K:0]    mag;
   logic          rnd;
   logic signed [K+1:0] quo_in;
   logic signed [K+1:0] quo_ff;

   assign un = num[NW-1] ? (~num + 1'b1) : num;
   assign ud = den[DW-1] ? (~den + 1'b1) : den;

   always_comb begin
      logic [DW:0] t;
      logic        ge;
      rem_in[0] = DW'(un >> K);
      low_in[0] = un[K-1:0];
      q_in[0]   = '0;
      for (int i = 0; i < K; i++) begin
         t  = {rem_ff[i], low_ff[i][K-1]};
         ge = (t >= {1'b0, ud_ff[i]});
         rem_in[i+1] = ge ? DW'(t - {1'b0, ud_ff[i]}) : t[DW-1:0];
         low_in[i+1] = {low_ff[i][K-2:0], 1'b0};
         q_in[i+1]   = {q_ff[i][K-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff    <= rem_in;
         low_ff    <= low_in;
         q_ff      <= q_in;
         ud_ff[0]  <= ud;
         neg_ff[0] <= num[NW-1] ^ den[DW-1];
         // quotient would need more than K bits
         ovf_ff[0] <= ((un >> K) >= NW'(ud));
         for (int i = 1; i <= K; i++) begin
            ud_ff[i]  <= ud_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            ovf_ff[i] <= ovf_ff[i-1];
         end
      end
   end

   // round bit: twice the remainder against the divisor
   assign rnd    = ({rem_ff[K], 1'b0} >= {1'b0, ud_ff[K]});
   assign mag    = ovf_ff[K] ? ((K+1)'(1) << K) : ((K+1)'(q_ff[K]) + (K+1)'(rnd));
   assign quo_in = neg_ff[K] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// ===== rtl/core/gaussian_fusion_2d.sv =====
// ----------------------------------------------------------------------------
// gaussian_fusion_2d
// Fuses two 2D Gaussian estimates in information form.
// ----------------------------------------------------------------------------
// Request beat: both means (Q16.16) and both covariances (Q8.32). Response
// beat: fused mean, fused covariance and a singular flag; when det(A), det(B)
// or det(A+B) is zero all fused fields are zero and singular is set.
// Works through C = B*inv(A+B)*A and mean = B*inv(A+B)*mu_a + A*inv(A+B)*mu_b,
// every output one rounded quotient by det(A+B), then saturated.
// A request beat reaches the response through 51 register stages: input
// register, two rounds of sliced two-stage multipliers each followed by a
// combine register, a 43-stage restoring divider, and the output register.
// Throughput is one beat per cycle unless the pipe stalls; the divider
// pipeline sets the depth.
// All stages advance together: when the response register is full and
// rsp_ready is low the whole pipe holds and req_ready drops; nothing is
// dropped or duplicated. Reset clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
module gaussian_fusion_2d (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  gfus2d_pkg::gfus2d_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gfus2d_pkg::gfus2d_rsp_type rsp_data
);

   import gfus2d_pkg::*;

   localparam int LAT = 1 + MULLAT + 1 + MULLAT + 1 + DIVLAT + 1;
   localparam int P_DET = EW + EW;
   localparam int P_DS  = SW + SW;
   localparam int P_Q   = EW + SW;
   localparam int P_T   = MW + SW;
   localparam int P_N   = EW + QW;
   localparam int P_V   = EW + TW;

   localparam logic signed [QOW-1:0] ONE_Q = 1;
   localparam logic signed [QOW-1:0] ZERO_Q = 0;
   localparam logic signed [QOW-1:0] X_HI = (ONE_Q <<< (MW-1)) - ONE_Q;
   localparam logic signed [QOW-1:0] X_LO = -(ONE_Q <<< (MW-1));
   localparam logic signed [QOW-1:0] C_HI = (ONE_Q <<< (OFW-1)) - ONE_Q;
   localparam logic signed [QOW-1:0] C_LO = -(ONE_Q <<< (OFW-1));

   function automatic logic signed [QOW-1:0] sat_q(input logic signed [QOW-1:0] v,
                                                  input logic signed [QOW-1:0] lo,
                                                  input logic signed [QOW-1:0] hi);
      logic signed [QOW-1:0] r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------- input register ----------------
   logic signed [EW-1:0] a00_ff, a01_ff, a11_ff, b00_ff, b01_ff, b11_ff;
   logic signed [MW-1:0] ma0_ff, ma1_ff, mb0_ff, mb1_ff;
   logic signed [SW-1:0] s00_ff, s01_ff, s11_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a00_ff <= $signed({1'b0, req_data.cov_a_xx});
         a01_ff <= req_data.cov_a_xy;
         a11_ff <= $signed({1'b0, req_data.cov_a_yy});
         b00_ff <= $signed({1'b0, req_data.cov_b_xx});
         b01_ff <= req_data.cov_b_xy;
         b11_ff <= $signed({1'b0, req_data.cov_b_yy});
         ma0_ff <= req_data.mean_a_x;
         ma1_ff <= req_data.mean_a_y;
         mb0_ff <= req_data.mean_b_x;
         mb1_ff <= req_data.mean_b_y;
         s00_ff <= $signed({2'b00, req_data.cov_a_xx} + {2'b00, req_data.cov_b_xx});
         s01_ff <= SW'(req_data.cov_a_xy) + SW'(req_data.cov_b_xy);
         s11_ff <= $signed({2'b00, req_data.cov_a_yy} + {2'b00, req_data.cov_b_yy});
      end
   end

   // ---------------- first multiply round ----------------
   logic signed [EW-1:0]    dt_a [4];
   logic signed [EW-1:0]    dt_b [4];
   logic signed [P_DET-1:0] dt_p [4];
   logic signed [SW-1:0]    ds_a [2];
   logic signed [SW-1:0]    ds_b [2];
   logic signed [P_DS-1:0]  ds_p [2];
   logic signed [EW-1:0]    qm_a [7];
   logic signed [SW-1:0]    qm_b [7];
   logic signed [P_Q-1:0]   qm_p [7];
   logic signed [MW-1:0]    tm_a [8];
   logic signed [SW-1:0]    tm_b [8];
   logic signed [P_T-1:0]   tm_p [8];

   always_comb begin
      dt_a[0] = a00_ff;  dt_b[0] = a11_ff;
      dt_a[1] = a01_ff;  dt_b[1] = a01_ff;
      dt_a[2] = b00_ff;  dt_b[2] = b11_ff;
      dt_a[3] = b01_ff;  dt_b[3] = b01_ff;
      ds_a[0] = s00_ff;  ds_b[0] = s11_ff;
      ds_a[1] = s01_ff;  ds_b[1] = s01_ff;
      // adj(S)*A terms; s01*a01 is shared by both diagonal entries
      qm_a[0] = a00_ff;  qm_b[0] = s11_ff;
      qm_a[1] = a01_ff;  qm_b[1] = s01_ff;
      qm_a[2] = a01_ff;  qm_b[2] = s11_ff;
      qm_a[3] = a11_ff;  qm_b[3] = s01_ff;
      qm_a[4] = a01_ff;  qm_b[4] = s00_ff;
      qm_a[5] = a00_ff;  qm_b[5] = s01_ff;
      qm_a[6] = a11_ff;  qm_b[6] = s00_ff;
      tm_a[0] = ma0_ff;  tm_b[0] = s11_ff;
      tm_a[1] = ma1_ff;  tm_b[1] = s01_ff;
      tm_a[2] = ma1_ff;  tm_b[2] = s00_ff;
      tm_a[3] = ma0_ff;  tm_b[3] = s01_ff;
      tm_a[4] = mb0_ff;  tm_b[4] = s11_ff;
      tm_a[5] = mb1_ff;  tm_b[5] = s01_ff;
      tm_a[6] = mb1_ff;  tm_b[6] = s00_ff;
      tm_a[7] = mb0_ff;  tm_b[7] = s01_ff;
   end

   for (genvar i = 0; i < 4; i++) begin : g_dt
      gfus2d_mul #(.WA(EW), .WB(EW), .CW(CHUNK)) u_mul (
         .clock(clock), .en(en), .a(dt_a[i]), .b(dt_b[i]), .p(dt_p[i]));
   end
   for (genvar i = 0; i < 2; i++) begin : g_ds
      gfus2d_mul #(.WA(SW), .WB(SW), .CW(CHUNK)) u_mul (
         .clock(clock), .en(en), .a(ds_a[i]), .b(ds_b[i]), .p(ds_p[i]));
   end
   for (genvar i = 0; i < 7; i++) begin : g_qm
      gfus2d_mul #(.WA(EW), .WB(SW), .CW(CHUNK)) u_mul (
         .clock(clock), .en(en), .a(qm_a[i]), .b(qm_b[i]), .p(qm_p[i]));
   end
   for (genvar i = 0; i < 8; i++) begin : g_tm
      gfus2d_mul #(.WA(MW), .WB(SW), .CW(CHUNK)) u_mul (
         .clock(clock), .en(en), .a(tm_a[i]), .b(tm_b[i]), .p(tm_p[i]));
   end

   // covariance elements follow the first round
   logic [6*EW-1:0]      ab_pack;
   logic [6*EW-1:0]      ab_dly;
   logic signed [EW-1:0] da00, da01, da11, db00, db01, db11;

   assign ab_pack = {a00_ff, a01_ff, a11_ff, b00_ff, b01_ff, b11_ff};

   gfus2d_dly #(.W(6*EW), .N(MULLAT + 1)) u_ab_dly (
      .clock(clock), .en(en), .d(ab_pack), .q(ab_dly));

   assign {da00, da01, da11, db00, db01, db11} = ab_dly;

   // ---------------- first combine ----------------
   logic                   sing_in, sing_ff;
   logic signed [DETW-1:0] dets_in, dets_ff;
   logic signed [QW-1:0]   q00_ff, q01_ff, q10_ff, q11_ff;
   logic signed [TW-1:0]   ta0_ff, ta1_ff, tb0_ff, tb1_ff;

   // a determinant is zero exactly when its two products match
   assign sing_in = (dt_p[0] == dt_p[1]) || (dt_p[2] == dt_p[3]) || (ds_p[0] == ds_p[1]);
   assign dets_in = DETW'(ds_p[0]) - DETW'(ds_p[1]);

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= sing_in;
         dets_ff <= dets_in;
         q00_ff  <= QW'(qm_p[0]) - QW'(qm_p[1]);
         q01_ff  <= QW'(qm_p[2]) - QW'(qm_p[3]);
         q10_ff  <= QW'(qm_p[4]) - QW'(qm_p[5]);
         q11_ff  <= QW'(qm_p[6]) - QW'(qm_p[1]);
         ta0_ff  <= TW'(tm_p[0]) - TW'(tm_p[1]);
         ta1_ff  <= TW'(tm_p[2]) - TW'(tm_p[3]);
         tb0_ff  <= TW'(tm_p[4]) - TW'(tm_p[5]);
         tb1_ff  <= TW'(tm_p[6]) - TW'(tm_p[7]);
      end
   end

   // ---------------- second multiply round ----------------
   logic signed [EW-1:0]  nm_a [6];
   logic signed [QW-1:0]  nm_b [6];
   logic signed [P_N-1:0] nm_p [6];
   logic signed [EW-1:0]  vm_a [8];
   logic signed [TW-1:0]  vm_b [8];
   logic signed [P_V-1:0] vm_p [8];

   always_comb begin
      nm_a[0] = db00;  nm_b[0] = q00_ff;
      nm_a[1] = db01;  nm_b[1] = q10_ff;
      nm_a[2] = db00;  nm_b[2] = q01_ff;
      nm_a[3] = db01;  nm_b[3] = q11_ff;
      nm_a[4] = db01;  nm_b[4] = q01_ff;
      nm_a[5] = db11;  nm_b[5] = q11_ff;
      vm_a[0] = db00;  vm_b[0] = ta0_ff;
      vm_a[1] = db01;  vm_b[1] = ta1_ff;
      vm_a[2] = db01;  vm_b[2] = ta0_ff;
      vm_a[3] = db11;  vm_b[3] = ta1_ff;
      vm_a[4] = da00;  vm_b[4] = tb0_ff;
      vm_a[5] = da01;  vm_b[5] = tb1_ff;
      vm_a[6] = da01;  vm_b[6] = tb0_ff;
      vm_a[7] = da11;  vm_b[7] = tb1_ff;
   end

   for (genvar i = 0; i < 6; i++) begin : g_nm
      gfus2d_mul #(.WA(EW), .WB(QW), .CW(CHUNK)) u_mul (
         .clock(clock), .en(en), .a(nm_a[i]), .b(nm_b[i]), .p(nm_p[i]));
   end
   for (genvar i = 0; i < 8; i++) begin : g_vm
      gfus2d_mul #(.WA(EW), .WB(TW), .CW(CHUNK)) u_mul (
         .clock(clock), .en(en), .a(vm_a[i]), .b(vm_b[i]), .p(vm_p[i]));
   end

   // determinant rides alongside the second round, lands with its products
   logic [DETW:0]          ds_dly;
   logic signed [DETW-1:0] dets_d;
   logic                   sing_d;

   gfus2d_dly #(.W(DETW + 1), .N(MULLAT)) u_det_dly (
      .clock(clock), .en(en), .d({sing_ff, dets_ff}), .q(ds_dly));

   assign {sing_d, dets_d} = ds_dly;

   // ---------------- second combine ----------------
   logic signed [NUMW-1:0] num_ff [5];
   logic signed [DETW-1:0] den_ff;
   logic                   sing2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= NUMW'(vm_p[0]) + NUMW'(vm_p[1]) + NUMW'(vm_p[4]) + NUMW'(vm_p[5]);
         num_ff[1] <= NUMW'(vm_p[2]) + NUMW'(vm_p[3]) + NUMW'(vm_p[6]) + NUMW'(vm_p[7]);
         num_ff[2] <= NUMW'(nm_p[0]) + NUMW'(nm_p[1]);
         num_ff[3] <= NUMW'(nm_p[2]) + NUMW'(nm_p[3]);
         num_ff[4] <= NUMW'(nm_p[4]) + NUMW'(nm_p[5]);
         den_ff    <= dets_d;
         sing2_ff  <= sing_d;
      end
   end

   // ---------------- dividers ----------------
   logic signed [QOW-1:0] quo [5];
   logic                  sing_q;

   for (genvar i = 0; i < 5; i++) begin : g_div
      gfus2d_div #(.NW(NUMW), .DW(DETW), .K(QBITS)) u_div (
         .clock(clock), .en(en), .num(num_ff[i]), .den(den_ff), .quo(quo[i]));
   end

   gfus2d_dly #(.W(1), .N(DIVLAT)) u_sing_dly (
      .clock(clock), .en(en), .d(sing2_ff), .q(sing_q));

   // ---------------- saturate and output register ----------------
   gfus2d_rsp_type        rsp_in, rsp_ff;
   logic signed [QOW-1:0] fx, fy, cxx, cxy, cyy;

   always_comb begin
      fx  = sat_q(quo[0], X_LO, X_HI);
      fy  = sat_q(quo[1], X_LO, X_HI);
      cxx = sat_q(quo[2], ZERO_Q, C_HI);
      cxy = sat_q(quo[3], C_LO, C_HI);
      cyy = sat_q(quo[4], ZERO_Q, C_HI);
      rsp_in = '0;
      rsp_in.singular = sing_q;
      if (!sing_q) begin
         rsp_in.fused_x      = fx[MW-1:0];
         rsp_in.fused_y      = fy[MW-1:0];
         rsp_in.fused_cov_xx = cxx[DGW-1:0];
         rsp_in.fused_cov_xy = cxy[OFW-1:0];
         rsp_in.fused_cov_yy = cyy[DGW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---------------- assertions ----------------
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |-> (rsp_data.fused_x == '0) &&
      (rsp_data.fused_y == '0) && (rsp_data.fused_cov_xx == '0) &&
      (rsp_data.fused_cov_xy == '0) && (rsp_data.fused_cov_yy == '0))
      else $error("singular beat with nonzero fields");

endmodule
